// ===== design/tiled_risk_grid_accumulator_assert.svh =====
// Assertion macros used by the checker of the risk grid accumulator.
// Plain text macros only; no dependencies.
`ifndef TILED_RISK_GRID_ACCUMULATOR_ASSERT_SVH
`define TILED_RISK_GRID_ACCUMULATOR_ASSERT_SVH

// Overlapping implication, checked outside reset.
`define TRGA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TRGA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// What must hold in the cycle after reset is sampled low.
`define TRGA_ASSERT_RESET(label, clk, rst_n, cons, msg) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/trga_pkg.sv =====
// Shared types and constants of the risk grid accumulator.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package trga_pkg;

  localparam int LAYER_W  = 4;
  localparam int TILE_W   = 6;
  localparam int AMOUNT_W = 16;
  localparam int POS_W    = 31;
  localparam int RISK_W   = 16;
  localparam int PITCH_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W    = 31;

  localparam int LAYER_LSB  = 0;
  localparam int COL_LSB    = LAYER_LSB + LAYER_W;
  localparam int ROW_LSB    = COL_LSB + TILE_W;
  localparam int AMOUNT_LSB = ROW_LSB + TILE_W;
  localparam int POSX_LSB   = AMOUNT_LSB + AMOUNT_W;
  localparam int POSY_LSB   = POSX_LSB + POS_W;
  localparam int IN_TDATA_W = 96;

  localparam int DIV_W     = 32;
  localparam int DIV_STEPS = 32;
  localparam int STEP_W    = 5;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_PITCH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TILES_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TILES_Y    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LAYERS     = 3'd6;

  typedef struct packed {
    logic capture;
    logic clr_wr;
    logic add_rd;
    logic add_wr;
    logic q_abs;
    logic q_step;
    logic q_chk;
    logic q_rd;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/trga_datapath.sv =====
// Datapath of the risk grid accumulator: configuration registers, counter memory,
// two serial dividers and the result register. Depends on trga_pkg.
`default_nettype none

module trga_datapath #(
  parameter int MAX_TILES_X = 32,
  parameter int MAX_TILES_Y = 32,
  parameter int MAX_LAYERS  = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  input  wire logic [trga_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [trga_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic [trga_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire trga_pkg::dp_cmd_t                 cmd,
  output trga_pkg::dp_stat_t                     stat,
  output logic [trga_pkg::RISK_W-1:0]            risk
);

  localparam int CW    = (MAX_TILES_X > 1) ? $clog2(MAX_TILES_X) : 1;
  localparam int RW    = (MAX_TILES_Y > 1) ? $clog2(MAX_TILES_Y) : 1;
  localparam int LW    = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int AW    = LW + RW + CW;
  localparam int DEPTH = 1 << AW;
  localparam int DW    = trga_pkg::DIV_W;
  localparam int PW    = trga_pkg::PITCH_W;

  logic                              enable_r;
  logic signed [trga_pkg::POS_W-1:0] origin_x_r;
  logic signed [trga_pkg::POS_W-1:0] origin_y_r;
  logic [PW-1:0]                     pitch_r;
  logic [trga_pkg::TILE_W-1:0]       tiles_x_r;
  logic [trga_pkg::TILE_W-1:0]       tiles_y_r;
  logic [trga_pkg::LAYER_W-1:0]      layers_r;

  logic [trga_pkg::LAYER_W-1:0]      layer_r;
  logic [trga_pkg::TILE_W-1:0]       col_r;
  logic [trga_pkg::TILE_W-1:0]       row_r;
  logic [trga_pkg::AMOUNT_W-1:0]     amount_r;
  logic [DW-1:0]                     diff_x_r;
  logic [DW-1:0]                     diff_y_r;

  logic [PW-1:0]                     divisor_r;
  logic [DW-1:0]                     dvd_x_r;
  logic [DW-1:0]                     dvd_y_r;
  logic [PW-1:0]                     rem_x_r;
  logic [PW-1:0]                     rem_y_r;
  logic                              neg_x_r;
  logic                              neg_y_r;

  logic                              q_ok_r;
  logic [AW-1:0]                     q_addr_r;
  logic [AW-1:0]                     clr_cnt_r;
  logic [trga_pkg::RISK_W-1:0]       mem [DEPTH];
  logic [trga_pkg::RISK_W-1:0]       rd_data_r;
  logic [trga_pkg::RISK_W-1:0]       risk_r;

  logic [trga_pkg::POS_W-1:0]        pos_x;
  logic [trga_pkg::POS_W-1:0]        pos_y;
  logic [AW-1:0]                     add_addr;
  logic                              add_ok;
  logic [trga_pkg::RISK_W:0]         sum;
  logic [trga_pkg::RISK_W-1:0]       sat;
  logic [PW:0]                       sh_x;
  logic [PW:0]                       sh_y;
  logic                              ge_x;
  logic                              ge_y;
  logic                              col_q_ok;
  logic                              row_q_ok;
  logic                              layer_ok;
  logic                              mem_we;
  logic [AW-1:0]                     wr_addr;
  logic [trga_pkg::RISK_W-1:0]       wr_data;
  logic                              mem_re;
  logic [AW-1:0]                     rd_addr;

  assign pos_x = in_tdata[trga_pkg::POSX_LSB +: trga_pkg::POS_W];
  assign pos_y = in_tdata[trga_pkg::POSY_LSB +: trga_pkg::POS_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      origin_x_r <= '0;
      origin_y_r <= '0;
      pitch_r    <= PW'(1);
      tiles_x_r  <= trga_pkg::TILE_W'(1);
      tiles_y_r  <= trga_pkg::TILE_W'(1);
      layers_r   <= trga_pkg::LAYER_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        trga_pkg::REG_ENABLE:     enable_r   <= cfg_data[0];
        trga_pkg::REG_ORIGIN_X:   origin_x_r <= cfg_data[trga_pkg::POS_W-1:0];
        trga_pkg::REG_ORIGIN_Y:   origin_y_r <= cfg_data[trga_pkg::POS_W-1:0];
        trga_pkg::REG_TILE_PITCH: pitch_r    <= cfg_data[PW-1:0];
        trga_pkg::REG_TILES_X:    tiles_x_r  <= cfg_data[trga_pkg::TILE_W-1:0];
        trga_pkg::REG_TILES_Y:    tiles_y_r  <= cfg_data[trga_pkg::TILE_W-1:0];
        trga_pkg::REG_LAYERS:     layers_r   <= cfg_data[trga_pkg::LAYER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      layer_r  <= in_tdata[trga_pkg::LAYER_LSB +: trga_pkg::LAYER_W];
      col_r    <= in_tdata[trga_pkg::COL_LSB +: trga_pkg::TILE_W];
      row_r    <= in_tdata[trga_pkg::ROW_LSB +: trga_pkg::TILE_W];
      amount_r <= in_tdata[trga_pkg::AMOUNT_LSB +: trga_pkg::AMOUNT_W];
      diff_x_r <= {pos_x[trga_pkg::POS_W-1], pos_x} - {origin_x_r[trga_pkg::POS_W-1], origin_x_r};
      diff_y_r <= {pos_y[trga_pkg::POS_W-1], pos_y} - {origin_y_r[trga_pkg::POS_W-1], origin_y_r};
    end
  end

  always_comb begin
    sh_x = {rem_x_r, dvd_x_r[DW-1]};
    sh_y = {rem_y_r, dvd_y_r[DW-1]};
    ge_x = sh_x >= {1'b0, divisor_r};
    ge_y = sh_y >= {1'b0, divisor_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.q_abs) begin
      divisor_r <= (pitch_r == '0) ? PW'(1) : pitch_r;
      neg_x_r   <= diff_x_r[DW-1];
      neg_y_r   <= diff_y_r[DW-1];
      dvd_x_r   <= diff_x_r[DW-1] ? (~diff_x_r + DW'(1)) : diff_x_r;
      dvd_y_r   <= diff_y_r[DW-1] ? (~diff_y_r + DW'(1)) : diff_y_r;
      rem_x_r   <= '0;
      rem_y_r   <= '0;
    end else if (cmd.q_step) begin
      dvd_x_r <= {dvd_x_r[DW-2:0], ge_x};
      dvd_y_r <= {dvd_y_r[DW-2:0], ge_y};
      rem_x_r <= ge_x ? PW'(sh_x - {1'b0, divisor_r}) : sh_x[PW-1:0];
      rem_y_r <= ge_y ? PW'(sh_y - {1'b0, divisor_r}) : sh_y[PW-1:0];
    end
  end

  // A negative offset is only valid when it truncates to tile zero.
  always_comb begin
    layer_ok = (32'(layer_r) < 32'(layers_r)) && (32'(layer_r) < 32'(MAX_LAYERS));
    col_q_ok = (!neg_x_r || dvd_x_r == '0) && (dvd_x_r < DW'(tiles_x_r))
               && (dvd_x_r < DW'(MAX_TILES_X));
    row_q_ok = (!neg_y_r || dvd_y_r == '0) && (dvd_y_r < DW'(tiles_y_r))
               && (dvd_y_r < DW'(MAX_TILES_Y));
    add_ok   = enable_r && (amount_r != '0) && layer_ok
               && (32'(col_r) < 32'(tiles_x_r)) && (32'(col_r) < 32'(MAX_TILES_X))
               && (32'(row_r) < 32'(tiles_y_r)) && (32'(row_r) < 32'(MAX_TILES_Y));
    add_addr = {LW'(layer_r), RW'(row_r), CW'(col_r)};
  end

  always_ff @(posedge clk) begin
    if (cmd.q_chk) begin
      q_ok_r   <= enable_r && layer_ok && col_q_ok && row_q_ok;
      q_addr_r <= {LW'(layer_r), RW'(dvd_y_r), CW'(dvd_x_r)};
    end
  end

  always_comb begin
    sum     = {1'b0, rd_data_r} + {1'b0, amount_r};
    sat     = sum[trga_pkg::RISK_W] ? '1 : sum[trga_pkg::RISK_W-1:0];
    mem_we  = cmd.clr_wr || (cmd.add_wr && add_ok);
    wr_addr = cmd.clr_wr ? clr_cnt_r : add_addr;
    wr_data = cmd.clr_wr ? '0 : sat;
    mem_re  = cmd.add_rd || cmd.q_rd;
    rd_addr = cmd.q_rd ? q_addr_r : add_addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      risk_r <= q_ok_r ? rd_data_r : '0;
    end
  end

  assign stat.clr_last = (clr_cnt_r == '1);
  assign risk          = risk_r;

endmodule

`default_nettype wire

// ===== design/trga_ctrl.sv =====
// Controller of the risk grid accumulator: sequences clearing, adds and queries.
// Drives the datapath through trga_pkg::dp_cmd_t and owns the result handshake.
`default_nettype none

module trga_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  input  wire logic               in_tuser,
  output logic                    in_tready,
  input  wire logic               out_tready,
  output logic                    out_tvalid,
  input  wire trga_pkg::dp_stat_t stat,
  output trga_pkg::dp_cmd_t       cmd
);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_ADD_RD = 9'b000000100,
    S_ADD_WR = 9'b000001000,
    S_Q_ABS  = 9'b000010000,
    S_Q_DIV  = 9'b000100000,
    S_Q_CHK  = 9'b001000000,
    S_Q_RD   = 9'b010000000,
    S_Q_OUT  = 9'b100000000
  } state_t;

  state_t                      state_r;
  state_t                      state_nxt;
  logic [trga_pkg::STEP_W-1:0] step_r;
  logic [trga_pkg::STEP_W-1:0] step_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic                        out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_tready = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
        if (in_tvalid) begin
          state_nxt = (in_tuser == trga_pkg::OP_QUERY) ? S_Q_ABS : S_ADD_RD;
        end
      end
      S_ADD_RD: begin
        cmd.add_rd = 1'b1;
        state_nxt  = S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd.add_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_Q_ABS: begin
        cmd.q_abs = 1'b1;
        state_nxt = S_Q_DIV;
      end
      S_Q_DIV: begin
        cmd.q_step = 1'b1;
        if (step_r == trga_pkg::STEP_W'(trga_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_Q_CHK;
        end
      end
      S_Q_CHK: begin
        cmd.q_chk = 1'b1;
        state_nxt = S_Q_RD;
      end
      S_Q_RD: begin
        cmd.q_rd  = 1'b1;
        state_nxt = S_Q_OUT;
      end
      S_Q_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (cmd.q_abs) begin
      step_nxt = '0;
    end else if (cmd.q_step) begin
      step_nxt = step_r + trga_pkg::STEP_W'(1);
    end
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// ===== design/tiled_risk_grid_accumulator.sv =====
// Top level of the tiled risk grid accumulator.
// Joins trga_ctrl and trga_datapath; depends on trga_pkg.
//
// Use: configuration registers are written on the cfg_ channel, which is always
// ready; index 0 enable, 1 origin_x, 2 origin_y, 3 tile_pitch, 4 tiles_x,
// 5 tiles_y, 6 layers. Write them only while the block is idle.
// Items enter on the in_ channel; in_tuser selects add (0) or query (1).
// An add passes through accept, counter read and saturating write, and gives no
// result. A query forms the offsets, runs the two bit-serial dividers side by
// side, then does the check, the memory read and the load of the result
// register, whose value is shown on out_. A new item is taken only once the
// block is through with the last one.
// After reset every entry of the counter memory is cleared, one entry per cycle:
// MAX_LAYERS * MAX_TILES_Y * MAX_TILES_X rounded up to powers of two per index
// (8192 entries at the defaults); in_tready stays low meanwhile.
// A waiting result sits in the output register while the next item is taken;
// a query that finishes while that result still waits for out_tready waits too.
`default_nettype none

module tiled_risk_grid_accumulator #(
  parameter int MAX_TILES_X = 32,
  parameter int MAX_TILES_Y = 32,
  parameter int MAX_LAYERS  = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [trga_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [trga_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // layer[3:0], tile_col[9:4], tile_row[15:10], amount[31:16],
  // pos_x[62:32], pos_y[93:63], zero[95:94]
  input  wire logic [trga_pkg::IN_TDATA_W-1:0] in_tdata,
  // operation[0]
  input  wire logic                            in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // risk[15:0]
  output logic [trga_pkg::RISK_W-1:0]          out_tdata
);

  trga_pkg::dp_cmd_t  cmd;
  trga_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  trga_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .stat       (stat),
    .cmd        (cmd)
  );

  trga_datapath #(
    .MAX_TILES_X (MAX_TILES_X),
    .MAX_TILES_Y (MAX_TILES_Y),
    .MAX_LAYERS  (MAX_LAYERS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .risk      (out_tdata)
  );

endmodule

`default_nettype wire

// ===== design/trga_checker.sv =====
// Port-level checker of the risk grid accumulator, bound to the top level.
// Uses the macros of tiled_risk_grid_accumulator_assert.svh.
`default_nettype none

`include "tiled_risk_grid_accumulator_assert.svh"

module trga_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  `TRGA_ASSERT_RESET(a_clear_after_reset, clk, rst_n, !in_tready && !out_tvalid,
                     "item taken or result shown right after reset")
  `TRGA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready,
                    "second item taken in the cycle after an accepted item")
  `TRGA_ASSERT_SAME(a_result_while_busy, clk, rst_n, $rose(out_tvalid), !$past(in_tready),
                    "result appeared while the block was idle")
  `TRGA_ASSERT_NEXT(a_result_held, clk, rst_n, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata), "stalled result changed or was dropped")

endmodule

bind tiled_risk_grid_accumulator trga_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== bench/tb_tiled_risk_grid_accumulator.sv =====
// Self-checking testbench for tiled_risk_grid_accumulator: adds and queries on the in_ stream,
// risk values checked against a scoreboard that keeps its own copy of the counter grid.
// Depends on trga_pkg and the RTL of the block; reads no files.
module tb_tiled_risk_grid_accumulator;
  import trga_pkg::*;

  localparam int GRID_X = 32;
  localparam int GRID_Y = 32;
  localparam int GRID_L = 8;
  localparam int HOLD_OFF = 8;
  localparam int ITEMS_PER_SETTING = 40;

  typedef struct {
    logic                op;
    logic [LAYER_W-1:0]  layer;
    logic [TILE_W-1:0]   col;
    logic [TILE_W-1:0]   row;
    logic [AMOUNT_W-1:0] amount;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
  } grid_item_t;

  class risk_scoreboard;
    logic [RISK_W-1:0]  counters [GRID_L*GRID_Y*GRID_X];
    logic [RISK_W-1:0]  pending_risk [$];
    logic               enable;
    logic [POS_W-1:0]   origin_x;
    logic [POS_W-1:0]   origin_y;
    logic [PITCH_W-1:0] pitch;
    logic [TILE_W-1:0]  tiles_x;
    logic [TILE_W-1:0]  tiles_y;
    logic [LAYER_W-1:0] layers;
    int                 errors;

    function new();
      foreach (counters[i]) counters[i] = '0;
      enable = 1'b0;
      origin_x = '0;
      origin_y = '0;
      pitch = 1;
      tiles_x = 1;
      tiles_y = 1;
      layers = 1;
      errors = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_ENABLE:     enable = data[0];
        REG_ORIGIN_X:   origin_x = data[POS_W-1:0];
        REG_ORIGIN_Y:   origin_y = data[POS_W-1:0];
        REG_TILE_PITCH: pitch = data[PITCH_W-1:0];
        REG_TILES_X:    tiles_x = data[TILE_W-1:0];
        REG_TILES_Y:    tiles_y = data[TILE_W-1:0];
        REG_LAYERS:     layers = data[LAYER_W-1:0];
        default: ;
      endcase
    endfunction

    function int span(int count, int cap);
      return (count > cap) ? cap : count;
    endfunction

    function bit tile_valid(longint l, longint r, longint c);
      return l >= 0 && l < span(layers, GRID_L) && r >= 0 && r < span(tiles_y, GRID_Y) &&
             c >= 0 && c < span(tiles_x, GRID_X);
    endfunction

    function int slot(longint l, longint r, longint c);
      return int'((l * GRID_Y + r) * GRID_X + c);
    endfunction

    function void note_item(grid_item_t it);
      int                sum;
      int                a;
      longint            div;
      longint            c;
      longint            r;
      logic [RISK_W-1:0] risk;
      if (it.op == OP_ADD) begin
        if (enable && it.amount != 0 && tile_valid(it.layer, it.row, it.col)) begin
          a = slot(it.layer, it.row, it.col);
          sum = int'(counters[a]) + int'(it.amount);
          counters[a] = (sum > 65535) ? 16'hFFFF : sum[RISK_W-1:0];
        end
      end else begin
        risk = '0;
        if (enable) begin
          div = (pitch == 0) ? 1 : longint'(pitch);
          c = (longint'($signed(it.pos_x)) - longint'($signed(origin_x))) / div;
          r = (longint'($signed(it.pos_y)) - longint'($signed(origin_y))) / div;
          if (tile_valid(it.layer, r, c)) risk = counters[slot(it.layer, r, c)];
        end
        pending_risk.push_back(risk);
      end
    endfunction

    task log_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_risk(logic [RISK_W-1:0] got);
      logic [RISK_W-1:0] want;
      if (pending_risk.size() == 0) begin
        log_mismatch($sformatf("risk %0d arrived with no query outstanding", got));
      end else begin
        want = pending_risk.pop_front();
        if (got !== want) log_mismatch($sformatf("risk %0d, predicted %0d", got, want));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [RISK_W-1:0]     out_tdata;

  risk_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hot_known = 1'b0;
  logic [LAYER_W-1:0] hot_layer;
  logic [TILE_W-1:0]  hot_row;
  logic [TILE_W-1:0]  hot_col;

  tiled_risk_grid_accumulator #(
    .MAX_TILES_X(GRID_X),
    .MAX_TILES_Y(GRID_Y),
    .MAX_LAYERS (GRID_L)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(negedge clk) begin
    out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_risk(out_tdata);
  end

  function automatic grid_item_t make_item(logic op, int layer, int col, int row, int amount,
                                           longint px, longint py);
    grid_item_t it;
    it.op = op;
    it.layer = LAYER_W'(layer);
    it.col = TILE_W'(col);
    it.row = TILE_W'(row);
    it.amount = AMOUNT_W'(amount);
    it.pos_x = POS_W'(px);
    it.pos_y = POS_W'(py);
    return it;
  endfunction

  function automatic grid_item_t random_item();
    grid_item_t it;
    int         roll;
    int         nl;
    int         ny;
    int         nx;
    longint     step;
    longint     ox;
    longint     oy;
    roll = $urandom_range(99);
    nl = sb.span(sb.layers, GRID_L);
    ny = sb.span(sb.tiles_y, GRID_Y);
    nx = sb.span(sb.tiles_x, GRID_X);
    if (nl == 0) nl = 1;
    if (ny == 0) ny = 1;
    if (nx == 0) nx = 1;
    it.op = OP_ADD;
    it.layer = LAYER_W'($urandom);
    it.col = TILE_W'($urandom);
    it.row = TILE_W'($urandom);
    it.amount = AMOUNT_W'($urandom);
    it.pos_x = POS_W'($urandom);
    it.pos_y = POS_W'($urandom);
    if (roll >= 80) begin
      it.op = $urandom_range(1) ? OP_QUERY : OP_ADD;
      return it;
    end
    if (hot_known && $urandom_range(1)) begin
      it.layer = hot_layer;
      it.row = hot_row;
      it.col = hot_col;
    end else begin
      it.layer = LAYER_W'($urandom_range(nl - 1));
      it.row = TILE_W'($urandom_range(ny - 1));
      it.col = TILE_W'($urandom_range(nx - 1));
    end
    if (roll < 40) begin
      it.amount = ($urandom_range(4) == 0) ? AMOUNT_W'($urandom_range(1, 65535))
                                           : AMOUNT_W'($urandom_range(1, 300));
      hot_known = 1'b1;
      hot_layer = it.layer;
      hot_row = it.row;
      hot_col = it.col;
    end else begin
      it.op = OP_QUERY;
      step = (sb.pitch == 0) ? 1 : longint'(sb.pitch);
      ox = longint'($signed(sb.origin_x));
      oy = longint'($signed(sb.origin_y));
      if ($urandom_range(9) == 0) begin
        // Offsets just below the origin truncate into the first tile.
        it.pos_x = POS_W'(ox - longint'($urandom_range(int'(step - 1))));
        it.pos_y = POS_W'(oy - longint'($urandom_range(int'(step - 1))));
      end else begin
        it.pos_x = POS_W'(ox + it.col * step + longint'($urandom_range(int'(step - 1))));
        it.pos_y = POS_W'(oy + it.row * step + longint'($urandom_range(int'(step - 1))));
      end
    end
    return it;
  endfunction

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(idx, data);
    @(negedge clk);
  endtask

  task program_grid(logic en, longint ox, longint oy, int pitch, int tx, int ty, int ly);
    write_reg(REG_ENABLE, CFG_W'(en));
    write_reg(REG_ORIGIN_X, CFG_W'(ox));
    write_reg(REG_ORIGIN_Y, CFG_W'(oy));
    write_reg(REG_TILE_PITCH, CFG_W'(pitch));
    write_reg(REG_TILES_X, CFG_W'(tx));
    write_reg(REG_TILES_Y, CFG_W'(ty));
    write_reg(REG_LAYERS, CFG_W'(ly));
    cfg_valid <= 1'b0;
  endtask

  task pick_setting(int phase, int k);
    longint ox;
    longint oy;
    int     pitch;
    ox = longint'($urandom_range(32'h7F80_0000)) - 64'sh3FC0_0000;
    oy = longint'($urandom_range(32'h7F80_0000)) - 64'sh3FC0_0000;
    pitch = ($urandom_range(9) < 7) ? $urandom_range(1, 64) : $urandom_range(1, 65535);
    if (k != 0) begin
      program_grid($urandom_range(7) != 0, ox, oy, pitch, $urandom_range(1, 32),
                   $urandom_range(1, 32), $urandom_range(1, 8));
    end else begin
      case (phase)
        0: program_grid(1'b1, -64'sh4000_0000, 64'sh3FFF_FFFF, 65535, 4, 3, 2);
        1: program_grid(1'b1, ox, oy, 0, 63, 63, 15);
        2: program_grid(1'b1, ox, oy, 1, 0, 0, 0);
        default: program_grid(1'b0, ox, oy, pitch, 32, 32, 8);
      endcase
    end
  endtask

  task idle_gap();
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task send_item(grid_item_t it);
    in_tvalid <= 1'b1;
    in_tuser <= it.op;
    in_tdata <= '0 | (IN_TDATA_W'(it.layer) << LAYER_LSB) | (IN_TDATA_W'(it.col) << COL_LSB) |
                (IN_TDATA_W'(it.row) << ROW_LSB) | (IN_TDATA_W'(it.amount) << AMOUNT_LSB) |
                (IN_TDATA_W'(it.pos_x) << POSX_LSB) | (IN_TDATA_W'(it.pos_y) << POSY_LSB);
    do @(posedge clk); while (!in_tready);
    sb.note_item(it);
    @(negedge clk);
  endtask

  task settle();
    in_tvalid <= 1'b0;
    while (sb.pending_risk.size() != 0) @(negedge clk);
    repeat (HOLD_OFF) @(negedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Tile (c, r) spans x in [-100 + 10c, -91 + 10c] and y in [50 + 10r, 59 + 10r].
    program_grid(1'b1, -100, 50, 10, 32, 32, 8);
    send_item(make_item(OP_QUERY, 0, 0, 0, 0, -100, 50));
    send_item(make_item(OP_ADD, 0, 0, 0, 1, 0, 0));
    send_item(make_item(OP_QUERY, 0, 0, 0, 0, -95, 59));
    send_item(make_item(OP_ADD, 7, 31, 31, 65535, 0, 0));
    send_item(make_item(OP_ADD, 7, 31, 31, 65535, 0, 0));
    send_item(make_item(OP_ADD, 7, 31, 31, 1, 0, 0));
    send_item(make_item(OP_QUERY, 7, 0, 0, 0, 219, 369));
    send_item(make_item(OP_ADD, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_ADD, 8, 0, 0, 5, 0, 0));
    send_item(make_item(OP_ADD, 15, 0, 0, 5, 0, 0));
    send_item(make_item(OP_ADD, 0, 32, 0, 5, 0, 0));
    send_item(make_item(OP_ADD, 0, 63, 0, 5, 0, 0));
    send_item(make_item(OP_ADD, 0, 0, 32, 5, 0, 0));
    send_item(make_item(OP_ADD, 0, 0, 63, 5, 0, 0));
    send_item(make_item(OP_QUERY, 0, 0, 0, 0, -91, 41));
    send_item(make_item(OP_QUERY, 0, 0, 0, 0, -110, 50));
    send_item(make_item(OP_QUERY, 0, 0, 0, 0, 220, 50));
    send_item(make_item(OP_QUERY, 15, 0, 0, 0, -100, 50));
    send_item(make_item(OP_QUERY, 8, 0, 0, 0, -100, 50));
    send_item(make_item(OP_QUERY, 0, 63, 63, 65535, 64'sh3FFF_FFFF, -64'sh4000_0000));
    send_item(make_item(OP_QUERY, 0, 0, 0, 0, -64'sh4000_0000, 64'sh3FFF_FFFF));
    send_item(make_item(OP_ADD, 3, 17, 9, 40000, 0, 0));
    send_item(make_item(OP_QUERY, 3, 0, 0, 0, 75, 143));
    settle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      for (int k = 0; k < 4; k++) begin
        pick_setting(phase, k);
        for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
          idle_gap();
          send_item(random_item());
          if (k == 1 && n == ITEMS_PER_SETTING / 2) settle();
        end
        settle();
      end
    end

    repeat (40) @(posedge clk);
    if (sb.pending_risk.size() != 0)
      sb.log_mismatch($sformatf("%0d queries never answered", sb.pending_risk.size()));
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
